>>> rtl/saq_pkg.sv
// saq_pkg: shared types, codes and constants for the sensor alarm qualifier.
// No dependencies; imported by saq_grade and the top level.
`default_nettype none

package saq_pkg;

  // Qualification phase of the channel
  typedef enum logic [2:0] {
    PH_DISABLED = 3'd0,
    PH_INIT     = 3'd1,
    PH_WARMUP   = 3'd2,
    PH_READY    = 3'd3,
    PH_ACTIVE   = 3'd4
  } phase_t;

  // Reported severity
  typedef enum logic [1:0] {
    SEV_NORMAL  = 2'd0,
    SEV_WARNING = 2'd1,
    SEV_ALARM   = 2'd2
  } severity_t;

  // Request action codes
  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_INIT   = 1'b1
  } action_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_ENABLE    = 3'd0,
    CFG_INPUT_ENABLE    = 3'd1,
    CFG_HIGH_LIMIT      = 3'd2,
    CFG_LOW_LIMIT       = 3'd3,
    CFG_WARNING_PERCENT = 3'd4,
    CFG_WARMUP_MS       = 3'd5,
    CFG_PERSIST_MS      = 3'd6
  } cfg_idx_t;

  // 999.0 in Q16.16; limits at or beyond these mask the severity checks
  localparam logic signed [31:0] LIMIT_OFF_HIGH = 32'sd65470464;
  localparam logic signed [31:0] LIMIT_OFF_LOW  = -32'sd65470464;

  // Init period length in ms
  localparam logic [31:0] INIT_PERIOD_MS = 32'd1000;

  // Register reset values
  localparam logic              RST_ALARM_ENABLE    = 1'b0;
  localparam logic              RST_INPUT_ENABLE    = 1'b1;
  localparam logic signed [31:0] RST_HIGH_LIMIT     = LIMIT_OFF_HIGH;
  localparam logic signed [31:0] RST_LOW_LIMIT      = LIMIT_OFF_LOW;
  localparam logic [6:0]        RST_WARNING_PERCENT = 7'd90;
  localparam logic [15:0]       RST_WARMUP_MS       = 16'd0;
  localparam logic [15:0]       RST_PERSIST_MS      = 16'd0;

  // Limits and band setting seen by the grading logic
  typedef struct packed {
    logic signed [31:0] high_limit;
    logic signed [31:0] low_limit;
    logic [6:0]         warning_percent;
  } grade_cfg_t;

  // Per-request grading inputs from the qualifier
  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
    logic               fault_pending;
    logic               persist_met;
  } grade_req_t;

endpackage

`default_nettype wire

>>> rtl/saq_in_if.sv
// saq_in_if: valid/ready channel carrying one sample request.
// Depends on nothing outside itself.
`default_nettype none

interface saq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        now;
  logic signed [31:0] sample_value;
  logic               sample_valid;

  modport source (output valid, action, now, sample_value, sample_valid, input ready);
  modport sink   (input valid, action, now, sample_value, sample_valid, output ready);
endinterface

`default_nettype wire

>>> rtl/saq_out_if.sv
// saq_out_if: valid/ready channel carrying one qualification result.
// Depends on nothing outside itself.
`default_nettype none

interface saq_out_if;
  logic       valid;
  logic       ready;
  logic       in_alarm;
  logic [1:0] severity;
  logic [2:0] alarm_state;

  modport source (output valid, in_alarm, severity, alarm_state, input ready);
  modport sink   (input valid, in_alarm, severity, alarm_state, output ready);
endinterface

`default_nettype wire

>>> rtl/saq_grade.sv
// saq_grade: severity grading of one reading against the limits and warning band.
// Depends on saq_pkg (grade_cfg_t, grade_req_t, severity_t, limit markers).
`default_nettype none

module saq_grade
  import saq_pkg::*;
(
  input  grade_cfg_t cfg,
  input  grade_req_t req,
  output severity_t  sev
);

  // 41 bits hold 100*value and limit*(200-pct) exactly
  localparam int unsigned PW = 41;

  logic signed [PW-1:0] v_ext;
  logic signed [PW-1:0] hi_ext;
  logic signed [PW-1:0] lo_ext;
  logic signed [PW-1:0] v_x100;
  logic signed [PW-1:0] hi_band;
  logic signed [PW-1:0] lo_band;
  logic [8:0]           lo_pct;
  logic                 hi_on;
  logic                 lo_on;
  logic                 hard_hi;
  logic                 hard_lo;
  logic                 warn_hi;
  logic                 warn_lo;
  logic                 hard;
  logic                 warn;

  assign v_ext  = {{(PW-32){req.value[31]}}, req.value};
  assign hi_ext = {{(PW-32){cfg.high_limit[31]}}, cfg.high_limit};
  assign lo_ext = {{(PW-32){cfg.low_limit[31]}}, cfg.low_limit};
  assign lo_pct = 9'd200 - {2'b00, cfg.warning_percent};

  // Band thresholds: 100*v against limit scaled by the percentage
  assign v_x100  = v_ext * $signed(PW'(100));
  assign hi_band = hi_ext * $signed({{(PW-7){1'b0}}, cfg.warning_percent});
  assign lo_band = lo_ext * $signed({{(PW-9){1'b0}}, lo_pct});

  // Markers at 999.0 / -999.0 (or beyond) switch a side off
  assign hi_on = cfg.high_limit < LIMIT_OFF_HIGH;
  assign lo_on = cfg.low_limit > LIMIT_OFF_LOW;

  assign hard_hi = hi_on && (req.value >= cfg.high_limit);
  assign hard_lo = lo_on && (req.value <= cfg.low_limit);
  assign warn_hi = hi_on && !hard_hi && (v_x100 >= hi_band);
  assign warn_lo = lo_on && !hard_lo && (v_x100 <= lo_band);
  assign hard    = hard_hi || hard_lo;
  assign warn    = warn_hi || warn_lo;

  // Severity select
  always_comb begin
    priority if (!req.valid) begin
      sev = SEV_NORMAL;
    end else if (hard && req.fault_pending && req.persist_met) begin
      sev = SEV_ALARM;
    end else if (warn || (hard && req.fault_pending)) begin
      sev = SEV_WARNING;
    end else begin
      sev = SEV_NORMAL;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sensor_alarm_qualifier.sv
// sensor_alarm_qualifier: top level; request register, phase machine, result register.
// Depends on saq_pkg, saq_in_if, saq_out_if and saq_grade.
//
//   channel   dir   handshake          payload
//   sample    in    valid/ready        action, now, sample_value, sample_valid
//   result    out   valid/ready        in_alarm, severity, alarm_state
//   cfg       in    cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// Requests pass both registers in turn; one per cycle while result.ready is high.
// The state update for a request happens as it moves from the request register
// into the result register, so the next request sees it in the following cycle.
// A stalled result holds the result register; the request register still fills,
// so one more request is taken before sample.ready drops.
// rst is synchronous; resets phase state, config and valid flags, not payload registers.
`default_nettype none

module sensor_alarm_qualifier
  import saq_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  saq_in_if.sink               sample,
  saq_out_if.source            result,
  input  wire                  cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic               alarm_enable;
  logic               input_enable;
  logic signed [31:0] high_limit;
  logic signed [31:0] low_limit;
  logic [6:0]         warning_percent;
  logic [15:0]        warmup_ms;
  logic [15:0]        persist_ms;

  // Request register
  logic               req_vld;
  logic               req_action;
  logic [31:0]        req_now;
  logic signed [31:0] req_value;
  logic               req_valid;

  // Result register
  logic               rsp_vld;
  logic               rsp_alarm;
  severity_t          rsp_sev;
  phase_t             rsp_phase;

  // Qualification state
  phase_t             phase, phase_next;
  logic [31:0]        entry_time, entry_time_next;
  logic [31:0]        fault_start, fault_start_next;
  logic               alarm_flag, alarm_flag_next;
  severity_t          last_severity, last_severity_next;

  logic               advance;
  logic [31:0]        since_entry;
  logic [31:0]        fault_base;
  logic [31:0]        since_fault;
  logic               violation;
  grade_cfg_t         g_cfg;
  grade_req_t         g_req;
  severity_t          g_sev;

  // Handshake: request register moves on when the result register is free
  assign advance      = req_vld && (!rsp_vld || result.ready);
  assign sample.ready = !req_vld || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_enable    <= RST_ALARM_ENABLE;
      input_enable    <= RST_INPUT_ENABLE;
      high_limit      <= RST_HIGH_LIMIT;
      low_limit       <= RST_LOW_LIMIT;
      warning_percent <= RST_WARNING_PERCENT;
      warmup_ms       <= RST_WARMUP_MS;
      persist_ms      <= RST_PERSIST_MS;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALARM_ENABLE:    alarm_enable    <= cfg_wdata[0];
        CFG_INPUT_ENABLE:    input_enable    <= cfg_wdata[0];
        CFG_HIGH_LIMIT:      high_limit      <= $signed(cfg_wdata[31:0]);
        CFG_LOW_LIMIT:       low_limit       <= $signed(cfg_wdata[31:0]);
        CFG_WARNING_PERCENT: warning_percent <= cfg_wdata[6:0];
        CFG_WARMUP_MS:       warmup_ms       <= cfg_wdata[15:0];
        CFG_PERSIST_MS:      persist_ms      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (sample.ready) begin
      req_vld <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      req_action <= sample.action;
      req_now    <= sample.now;
      req_value  <= sample.sample_value;
      req_valid  <= sample.sample_valid;
    end
  end

  // Elapsed times, modulo 2^32; a fault with no start yet counts from this request
  assign since_entry = req_now - entry_time;
  assign violation   = req_valid && ((req_value >= high_limit) || (req_value <= low_limit));
  assign fault_base  = (fault_start == '0) ? req_now : fault_start;
  assign since_fault = req_now - fault_base;

  // Phase machine: next state
  always_comb begin
    phase_next         = phase;
    entry_time_next    = entry_time;
    fault_start_next   = fault_start;
    alarm_flag_next    = alarm_flag;
    priority if (action_t'(req_action) == ACT_INIT) begin
      phase_next       = alarm_enable ? PH_INIT : PH_DISABLED;
      entry_time_next  = req_now;
      fault_start_next = '0;
      alarm_flag_next  = 1'b0;
    end else if (!alarm_enable || !input_enable) begin
      phase_next      = PH_DISABLED;
      alarm_flag_next = 1'b0;
    end else begin
      unique case (phase)
        PH_INIT: begin
          if (since_entry > INIT_PERIOD_MS) begin
            phase_next      = PH_WARMUP;
            entry_time_next = req_now;
          end
          alarm_flag_next = 1'b0;
        end
        PH_WARMUP: begin
          if (req_valid && (since_entry > {16'd0, warmup_ms})) begin
            phase_next      = PH_READY;
            entry_time_next = req_now;
          end
          alarm_flag_next = 1'b0;
        end
        PH_READY, PH_ACTIVE: begin
          if (violation) begin
            if (fault_start == '0) begin
              fault_start_next = req_now;
            end
            if (since_fault >= {16'd0, persist_ms}) begin
              alarm_flag_next = 1'b1;
              phase_next      = PH_ACTIVE;
            end
          end else begin
            fault_start_next = '0;
            alarm_flag_next  = 1'b0;
            if (phase == PH_ACTIVE) begin
              phase_next = PH_READY;
            end
          end
        end
        default: begin
          alarm_flag_next = 1'b0;
        end
      endcase
    end
  end

  // Phase machine: severity output
  always_comb begin
    last_severity_next = last_severity;
    priority if (action_t'(req_action) == ACT_INIT) begin
      last_severity_next = SEV_NORMAL;
    end else if (alarm_enable && input_enable &&
                 (phase == PH_READY || phase == PH_ACTIVE)) begin
      last_severity_next = g_sev;
    end else begin
      last_severity_next = last_severity;
    end
  end

  // Severity grading
  assign g_cfg = '{high_limit: high_limit, low_limit: low_limit,
                   warning_percent: warning_percent};
  assign g_req = '{value: req_value, valid: req_valid,
                   fault_pending: (fault_start_next != '0),
                   persist_met: (since_fault >= {16'd0, persist_ms})};

  saq_grade u_grade (
    .cfg (g_cfg),
    .req (g_req),
    .sev (g_sev)
  );

  // State update on each request that moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DISABLED;
      entry_time    <= '0;
      fault_start   <= '0;
      alarm_flag    <= 1'b0;
      last_severity <= SEV_NORMAL;
    end else if (advance) begin
      phase         <= phase_next;
      entry_time    <= entry_time_next;
      fault_start   <= fault_start_next;
      alarm_flag    <= alarm_flag_next;
      last_severity <= last_severity_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (advance) begin
      rsp_vld <= 1'b1;
    end else if (result.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_alarm <= alarm_flag_next;
      rsp_sev   <= last_severity_next;
      rsp_phase <= phase_next;
    end
  end

  assign result.valid       = rsp_vld;
  assign result.in_alarm    = rsp_alarm;
  assign result.severity    = rsp_sev;
  assign result.alarm_state = rsp_phase;

endmodule

`default_nettype wire
